// ----- sv/spq_pkg.sv -----
// Shared types, sizes and codes for the sorted priority queue.
// No dependencies; every other file refers to it by scoped name.
`default_nettype none

package spq_pkg;

    localparam int DEPTH     = 16;
    localparam int PRIO_BITS = 8;
    localparam int CNT_W     = $clog2(DEPTH + 1);

    localparam logic FN_INSERT = 1'b0;
    localparam logic FN_REMOVE = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef logic [PRIO_BITS-1:0] t_prio;
    typedef logic [CNT_W-1:0]     t_count;

    typedef struct packed {
        logic               func;
        logic signed [31:0] in_value;
        logic [7:0]         in_priority;
    } t_req;

    typedef struct packed {
        logic signed [31:0] out_value;
        logic [7:0]         out_priority;
        logic               removed;
        logic [1:0]         status;
        logic [4:0]         occupancy;
    } t_rsp;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // apply it to the cell chain and load the result
    } t_cmd;

    // keep the low PRIO_BITS bits of the 8-bit field, zero-extend above it
    function automatic t_prio prio_from_field(input logic [7:0] p);
        logic [31:0] w;
        t_prio       r;
        w = {24'b0, p};
        for (int i = 0; i < PRIO_BITS; i++) begin
            r[i] = w[i];
        end
        return r;
    endfunction

    function automatic logic [7:0] prio_to_field(input t_prio p);
        logic [31:0] w;
        w = 32'(p);
        return w[7:0];
    endfunction

endpackage

`default_nettype wire

// ----- sv/spq_ctrl.sv -----
// Sequencer for the sorted priority queue: handshakes and item phases.
// Depends on spq_pkg.
`default_nettype none

module spq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output spq_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   slot_free;

    // result slot is free, or its item leaves at this edge
    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = !((r_state == S_IDLE) && slot_free);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cmd.capture = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

`default_nettype wire

// ----- sv/spq_dp.sv -----
// Datapath for the sorted priority queue: shift-register cell chain,
// entry count, request and result registers. Depends on spq_pkg.
`default_nettype none

module spq_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire spq_pkg::t_cmd i_cmd,
    input  wire spq_pkg::t_req i_req,
    output spq_pkg::t_rsp      o_rsp
);

    localparam int D = spq_pkg::DEPTH;

    logic                  r_func;
    logic signed [31:0]    r_new_val;
    spq_pkg::t_prio        r_new_pri;
    logic signed [31:0]    r_val [D];
    spq_pkg::t_prio        r_pri [D];
    spq_pkg::t_count       r_count, n_count;
    spq_pkg::t_rsp         r_rsp, n_rsp;
    logic [D-1:0]          ge;
    logic                  full, empty, do_ins, do_rem;

    // a cell is "ge" if empty or holding a priority not below the new one;
    // the chain is sorted so ge is monotone and the first ge cell is the slot
    for (genvar g = 0; g < D; g++) begin : g_cmp
        assign ge[g] = (spq_pkg::CNT_W'(g) >= r_count) || (r_pri[g] >= r_new_pri);
    end

    assign full   = (r_count == spq_pkg::CNT_W'(D));
    assign empty  = (r_count == '0);
    assign do_ins = (r_func == spq_pkg::FN_INSERT) && !full;
    assign do_rem = (r_func == spq_pkg::FN_REMOVE) && !empty;

    always_comb begin
        n_count = r_count;
        n_rsp   = '0;
        if (r_func == spq_pkg::FN_INSERT) begin
            if (full) begin
                n_rsp.status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + spq_pkg::t_count'(1);
            end
        end else begin
            if (empty) begin
                n_rsp.status = spq_pkg::ST_EMPTY;
            end else begin
                n_count            = r_count - spq_pkg::t_count'(1);
                n_rsp.out_value    = r_val[0];
                n_rsp.out_priority = spq_pkg::prio_to_field(r_pri[0]);
                n_rsp.removed      = 1'b1;
            end
        end
        n_rsp.occupancy = 5'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_req.func;
            r_new_val <= i_req.in_value;
            r_new_pri <= spq_pkg::prio_from_field(i_req.in_priority);
        end
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    // cell chain: insert shifts towards the tail, remove towards the head
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            for (int i = 0; i < D; i++) begin
                if (do_ins) begin
                    if (i > 0 && ge[(i > 0) ? i - 1 : 0]) begin
                        r_val[i] <= r_val[(i > 0) ? i - 1 : 0];
                        r_pri[i] <= r_pri[(i > 0) ? i - 1 : 0];
                    end else if (ge[i]) begin
                        r_val[i] <= r_new_val;
                        r_pri[i] <= r_new_pri;
                    end
                end else if (do_rem && i < D - 1) begin
                    r_val[i] <= r_val[(i < D - 1) ? i + 1 : i];
                    r_pri[i] <= r_pri[(i < D - 1) ? i + 1 : i];
                end
            end
        end
    end

    assign o_rsp = r_rsp;

endmodule

`default_nettype wire

// ----- sv/sorted_priority_queue.sv -----
// Top level of the sorted priority queue: sequencer plus cell-chain datapath.
// Depends on spq_pkg, spq_ctrl and spq_dp.
//
// Usage
//   Request channel (i_in_valid / o_in_stall / i_req): one item is an insert
//   (value and priority) or a remove of the head, lowest priority number first.
//   Among equal priorities the most recently inserted entry leaves first.
//   Response channel (o_out_valid / i_out_stall / o_rsp): exactly one item per
//   request, in request order: removed entry or zeros, status, occupancy.
//   Sequencing: a new request is taken only in the idle phase, so one item is
//   in work at a time; the sequencer captures the request into the request
//   registers, then updates the 16-cell chain, which compares all entries at
//   once against the new priority, and loads the result register.
//   Stall: the result register holds its item while i_out_stall is high; a new
//   request is still accepted as long as the result leaves at that same edge.
//   Reset (i_rst_n low, synchronous): queue empty, no result pending. Entry
//   storage is not cleared; cells beyond the count are never observed.
//   Full queue: insert is dropped with status full. Empty queue: remove gives
//   status empty and zero payload.
`default_nettype none

module sorted_priority_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  wire spq_pkg::t_req i_req,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output spq_pkg::t_rsp      o_rsp
);

    spq_pkg::t_cmd cmd;

    // handshakes and phase sequencing
    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // sorted entry chain, count and result register
    spq_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire

// ----- sv/spq_chk.sv -----
// Port-level checker for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.
`default_nettype none

module spq_chk (
    input wire logic           i_clk,
    input wire logic           i_rst_n,
    input wire logic           i_in_valid,
    input wire logic           o_in_stall,
    input wire spq_pkg::t_req  i_req,
    input wire logic           o_out_valid,
    input wire logic           i_out_stall,
    input wire spq_pkg::t_rsp  o_rsp
);

    // one item in flight: no accept straight after an accept
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("request accepted while previous item still in work");

    // result appears once the update phase after acceptance has loaded it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> ##1 o_out_valid)
        else $error("result missing after accepted item");

    // occupancy never beyond the queue depth
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (32'(o_rsp.occupancy) <= spq_pkg::DEPTH))
        else $error("occupancy beyond depth");

    // a returned entry always comes with ok status
    a_removed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rsp.removed) |-> (o_rsp.status == spq_pkg::ST_OK))
        else $error("removed entry with error status");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_rsp)))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue spq_chk u_spq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_req       (i_req),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_rsp       (o_rsp)
);

`default_nettype wire
